FILE: src/pfde_pkg.sv
// ---------------------------------------------------------------------------
// pfde_pkg
// Shared types and constants of the page framebuffer draw engine.
// ---------------------------------------------------------------------------
`default_nettype none
package pfde_pkg;

	typedef enum logic [2:0] {
		CMD_PIXEL = 3'd0,
		CMD_HLINE = 3'd1,
		CMD_VLINE = 3'd2,
		CMD_RECT  = 3'd3,
		CMD_GLYPH = 3'd4,
		CMD_READ  = 3'd5
	} cmd_t;

	localparam int GLYPH_BITS = 48;
	localparam int GLYPH_ROWS = 8;
	localparam int GLYPH_COLS = 6;
	localparam int COORD_W    = 10;
	localparam int DIM_W      = 8;
	localparam int OUTLINE_BANDS = 4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic in_ready;
		logic clr_step;
		logic load;
		logic setup;
		logic px_read;
		logic px_write;
		logic adv;
		logic rd_issue;
		logic rd_capture;
		logic res_load;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_valid;
		logic in_is_read;
		logic in_is_draw;
		logic region_empty;
		logic last_px;
		logic last_region;
		logic clear_last;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

FILE: src/pfde_ifs.sv
// ---------------------------------------------------------------------------
// pfde_ifs
// Valid/ready channels for draw commands and their result items.
// ---------------------------------------------------------------------------
`default_nettype none
interface pfde_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [6:0]  pos_x;
	logic [5:0]  pos_y;
	logic [7:0]  width_px;
	logic [6:0]  height_px;
	logic [6:0]  outline_px;
	logic        ink;
	logic [31:0] glyph_main;
	logic [15:0] glyph_tail;
	logic        large_req;
	logic [9:0]  byte_index;

	modport source (output valid, cmd, pos_x, pos_y, width_px, height_px, outline_px, ink,
		glyph_main, glyph_tail, large_req, byte_index, input ready);
	modport sink (input valid, cmd, pos_x, pos_y, width_px, height_px, outline_px, ink,
		glyph_main, glyph_tail, large_req, byte_index, output ready);
endinterface

interface pfde_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       is_read;

	modport source (output valid, read_data, is_read, input ready);
	modport sink (input valid, read_data, is_read, output ready);
endinterface
`default_nettype wire

FILE: src/pfde_ram.sv
// ---------------------------------------------------------------------------
// pfde_ram
// Generic single-port RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module pfde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic                     we,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

FILE: src/pfde_ctrl.sv
// ---------------------------------------------------------------------------
// pfde_ctrl
// Sequencer for clearing, pixel read-modify-write walks and byte reads.
// ---------------------------------------------------------------------------
`default_nettype none
module pfde_ctrl import pfde_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dp_status_t st,
	output ctrl_cmd_t       ctl
);
	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_SETUP = 9'b000000100,
		S_PRD   = 9'b000001000,
		S_PWR   = 9'b000010000,
		S_ADV   = 9'b000100000,
		S_RDB   = 9'b001000000,
		S_RDB2  = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		ctl = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				ctl.clr_step = 1'b1;
				if (st.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				ctl.in_ready = 1'b1;
				if (st.in_valid) begin
					ctl.load = 1'b1;
					if (st.in_is_read) state_d = S_RDB;
					else if (st.in_is_draw) state_d = S_SETUP;
					else state_d = S_DONE;
				end
			end
			S_SETUP: begin
				ctl.setup = 1'b1;
				state_d = st.region_empty ? S_ADV : S_PRD;
			end
			S_PRD: begin
				ctl.px_read = 1'b1;
				state_d = S_PWR;
			end
			S_PWR: begin
				ctl.px_write = 1'b1;
				state_d = st.last_px ? S_ADV : S_PRD;
			end
			S_ADV: begin
				if (st.last_region) begin
					state_d = S_DONE;
				end else begin
					ctl.adv = 1'b1;
					state_d = S_SETUP;
				end
			end
			S_RDB: begin
				ctl.rd_issue = 1'b1;
				state_d = S_RDB2;
			end
			S_RDB2: begin
				ctl.rd_capture = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					ctl.res_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end
endmodule
`default_nettype wire

FILE: src/pfde_datapath.sv
// ---------------------------------------------------------------------------
// pfde_datapath
// Command registers, region walker, framebuffer RAM and result register.
// ---------------------------------------------------------------------------
`default_nettype none
module pfde_datapath import pfde_pkg::*; #(
	parameter int DISPLAY_WIDTH = 128,
	parameter int DISPLAY_PAGES = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire ctrl_cmd_t ctl,
	output dp_status_t st,
	pfde_cmd_if.sink   req,
	pfde_res_if.source rsp
);
	localparam int DEPTH = DISPLAY_WIDTH * DISPLAY_PAGES;
	localparam int AW    = $clog2(DEPTH);
	localparam int ROWS  = DISPLAY_PAGES * 8;
	localparam int IDX_W = 13;

	// Latched command fields.
	cmd_t                  cmd_q;
	logic [COORD_W-1:0]    x0_q, y0_q;
	logic [DIM_W-1:0]      w_q, h_q, t_q;
	logic                  ink_q, large_q;
	logic [GLYPH_BITS-1:0] glyph_q;
	logic [9:0]            bidx_q;

	// Region walker.
	logic [1:0]            rg_q;
	logic [COORD_W-1:0]    rx_q, ry_q;
	logic [DIM_W-1:0]      rw_q, rh_q, i_q, j_q;
	logic [COORD_W-1:0]    nx, ny;
	logic [DIM_W-1:0]      nw, nh;
	logic                  outline;

	logic [AW-1:0]         clr_q;
	logic [7:0]            res_data_q, out_data_q;
	logic                  res_rd_q, out_rd_q, out_valid_q;

	logic [COORD_W-1:0]    px_x, px_y;
	logic                  in_bounds, on_px, gbit;
	logic [IDX_W-1:0]      px_idx, bidx13;
	logic [5:0]            gidx;
	logic [2:0]            gcol, grow;
	logic [7:0]            mask, rdata, wdata, px_wdata;
	logic [AW-1:0]         addr;
	logic                  we;

	assign outline = (cmd_q == CMD_RECT) && (t_q != '0);

	// Next region geometry.
	always_comb begin
		nx = x0_q;
		ny = y0_q;
		nw = 8'd1;
		nh = 8'd1;
		case (cmd_q)
			CMD_HLINE: nw = w_q;
			CMD_VLINE: nh = h_q;
			CMD_RECT: begin
				if (!outline) begin
					nw = w_q;
					nh = h_q;
				end else begin
					case (rg_q)
						2'd0: begin
							nw = w_q;
							nh = t_q;
						end
						2'd1: begin
							ny = y0_q + COORD_W'(h_q) - COORD_W'(t_q);
							nw = w_q;
							nh = t_q;
						end
						2'd2: begin
							nw = t_q;
							nh = h_q;
						end
						default: begin
							nx = x0_q + COORD_W'(w_q) - COORD_W'(t_q);
							nw = t_q;
							nh = h_q;
						end
					endcase
				end
			end
			CMD_GLYPH: begin
				nw = large_q ? DIM_W'(2 * GLYPH_COLS) : DIM_W'(GLYPH_COLS);
				nh = large_q ? DIM_W'(2 * GLYPH_ROWS) : DIM_W'(GLYPH_ROWS);
			end
			default: ;
		endcase
	end

	// Current pixel.
	assign px_x = rx_q + COORD_W'(i_q);
	assign px_y = ry_q + COORD_W'(j_q);
	assign in_bounds = !px_x[COORD_W-1] && (px_x < COORD_W'(DISPLAY_WIDTH))
		&& !px_y[COORD_W-1] && (px_y < COORD_W'(ROWS));
	assign px_idx = IDX_W'(px_x) + IDX_W'(px_y[COORD_W-2:3]) * IDX_W'(DISPLAY_WIDTH);

	assign gcol = large_q ? i_q[3:1] : i_q[2:0];
	assign grow = large_q ? j_q[3:1] : j_q[2:0];
	assign gidx = {gcol, grow};
	assign gbit = glyph_q[6'(GLYPH_BITS - 1) - gidx];
	assign on_px = (cmd_q == CMD_GLYPH) ? (ink_q ? gbit : !gbit) : ink_q;

	assign mask = 8'd1 << px_y[2:0];
	assign px_wdata = on_px ? (rdata | mask) : (rdata & ~mask);

	assign bidx13 = IDX_W'(bidx_q);

	always_comb begin
		if (ctl.clr_step) begin
			addr = clr_q;
		end else if (ctl.rd_issue) begin
			addr = bidx13[AW-1:0];
		end else begin
			addr = px_idx[AW-1:0];
		end
	end
	assign we = ctl.clr_step || (ctl.px_write && in_bounds);
	assign wdata = ctl.clr_step ? 8'd0 : px_wdata;

	pfde_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.addr (addr),
		.we   (we),
		.wdata(wdata),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= cmd_t'(req.cmd);
			x0_q    <= COORD_W'(req.pos_x);
			y0_q    <= COORD_W'(req.pos_y);
			w_q     <= req.width_px;
			h_q     <= DIM_W'(req.height_px);
			t_q     <= DIM_W'(req.outline_px);
			ink_q   <= req.ink;
			large_q <= req.large_req;
			glyph_q <= {req.glyph_main, req.glyph_tail};
			bidx_q  <= req.byte_index;
			rg_q    <= '0;
			res_data_q <= '0;
			res_rd_q   <= (req.cmd == CMD_READ);
		end else if (ctl.adv) begin
			rg_q <= rg_q + 2'd1;
		end
		if (ctl.setup) begin
			rx_q <= nx;
			ry_q <= ny;
			rw_q <= nw;
			rh_q <= nh;
			i_q  <= '0;
			j_q  <= '0;
		end else if (ctl.px_write) begin
			if (i_q == rw_q - 8'd1) begin
				i_q <= '0;
				j_q <= j_q + 8'd1;
			end else begin
				i_q <= i_q + 8'd1;
			end
		end
		if (ctl.rd_capture) begin
			res_data_q <= (bidx13 < IDX_W'(DEPTH)) ? rdata : 8'd0;
		end
		if (ctl.res_load) begin
			out_data_q <= res_data_q;
			out_rd_q   <= res_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.clr_step) clr_q <= clr_q + AW'(1);
			if (ctl.res_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	assign req.ready     = ctl.in_ready;
	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = out_data_q;
	assign rsp.is_read   = out_rd_q;

	assign st.in_valid     = req.valid;
	assign st.in_is_read   = (req.cmd == CMD_READ);
	assign st.in_is_draw   = (req.cmd <= CMD_GLYPH);
	assign st.region_empty = (nw == '0) || (nh == '0);
	assign st.last_px      = (i_q == rw_q - 8'd1) && (j_q == rh_q - 8'd1);
	assign st.last_region  = !outline || (rg_q == 2'(OUTLINE_BANDS - 1));
	assign st.clear_last   = (clr_q == AW'(DEPTH - 1));
	assign st.out_free     = !out_valid_q || rsp.ready;
endmodule
`default_nettype wire

FILE: src/page_framebuffer_draw_engine.sv
// ---------------------------------------------------------------------------
// page_framebuffer_draw_engine
// Drawing engine over a 1-bit page-organized framebuffer with byte readback.
// ---------------------------------------------------------------------------
// The req channel carries one drawing or readback command per item; the rsp
// channel returns exactly one item per command. Draw commands answer with
// read_data zero and is_read zero; the read command returns the addressed
// byte with is_read set, and a byte index past the store reads as zero.
// Each drawn pixel takes a read step and a write step: the byte is read from
// the single-port framebuffer RAM, then written back with the pixel bit
// changed. Other draw commands walk a single region; an outlined rectangle
// walks four bands. A glyph covers 48 pixels, or 192 at double scale. A read
// issues the RAM address, then captures the byte. Pixels off the display
// still take their read and write steps but leave the store alone. One item
// is worked on at a time. After reset the engine sweeps all
// DISPLAY_WIDTH * DISPLAY_PAGES bytes of the store to zero, one byte per
// cycle, and holds req.ready low meanwhile. The result sits in an output
// register: a new item is accepted while it waits, and the engine only
// stalls when it must hand over the next result and the receiver still
// holds off.
// ---------------------------------------------------------------------------
`default_nettype none
module page_framebuffer_draw_engine import pfde_pkg::*; #(
	parameter int DISPLAY_WIDTH = 128,
	parameter int DISPLAY_PAGES = 8
) (
	input wire logic   clk,
	input wire logic   arst_n,
	pfde_cmd_if.sink   req,
	pfde_res_if.source rsp
);
	// Controller and datapath meet only through these two structs.
	ctrl_cmd_t  ctl;
	dp_status_t st;

	pfde_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.st    (st),
		.ctl   (ctl)
	);

	pfde_datapath #(
		.DISPLAY_WIDTH(DISPLAY_WIDTH),
		.DISPLAY_PAGES(DISPLAY_PAGES)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.st    (st),
		.req   (req),
		.rsp   (rsp)
	);
endmodule
`default_nettype wire

FILE: test/tb_ifs.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_ifs
// Testbench-side holder for a command item used by the stimulus tasks.
// ---------------------------------------------------------------------------
package tb_pfde_pkg;
	import pfde_pkg::*;

	typedef struct {
		cmd_t        cmd;
		logic [2:0]  raw_cmd;
		logic [6:0]  pos_x;
		logic [5:0]  pos_y;
		logic [7:0]  width_px;
		logic [6:0]  height_px;
		logic [6:0]  outline_px;
		logic        ink;
		logic [31:0] glyph_main;
		logic [15:0] glyph_tail;
		logic        large_req;
		logic [9:0]  byte_index;
	} draw_item_t;
endpackage

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page framebuffer draw engine.
// ---------------------------------------------------------------------------
// A shadow framebuffer in the bench is updated for every accepted command, and
// the expected result item is queued. A checker process compares every result
// against the oldest expected one. Both channel sides idle at random, and one
// phase holds the receiver off for a long stretch to fill the engine.
// ---------------------------------------------------------------------------
module tb_top;
	import pfde_pkg::*;
	import tb_pfde_pkg::*;

	localparam int FB_WIDTH = 128;
	localparam int FB_PAGES = 8;
	localparam int FB_BYTES = FB_WIDTH * FB_PAGES;
	localparam int FB_ROWS  = FB_PAGES * 8;
	localparam logic [2:0] CMD_UNUSED_A = 3'd6;
	localparam logic [2:0] CMD_UNUSED_B = 3'd7;
	localparam longint CYCLE_LIMIT = 64'd12000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pfde_cmd_if req ();
	pfde_res_if rsp ();

	page_framebuffer_draw_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #4 clk = ~clk;

	// Shadow copy of the frame store and the queue of results still owed.
	logic [7:0] shadow_fb [FB_BYTES];
	logic [8:0] owed_results [$];
	int mismatch_count = 0;
	longint cycle_count = 0;
	bit hold_on = 1'b0;   // while set, the receiver stays off
	bit idle_sender = 1'b1;
	bit idle_receiver = 1'b1;

	// Sets or clears one pixel of the shadow store; pixels off the display are dropped.
	function automatic void plot_px(int x, int y, bit on);
		int idx;
		if (x < 0 || y < 0 || x >= FB_WIDTH || y >= FB_ROWS) begin
			return;
		end
		idx = x + (y / 8) * FB_WIDTH;
		shadow_fb[idx][y % 8] = on;
	endfunction

	function automatic void plot_hline(int x, int y, int len, bit on);
		for (int i = 0; i < len; i++) plot_px(x + i, y, on);
	endfunction

	function automatic void plot_vline(int x, int y, int len, bit on);
		for (int i = 0; i < len; i++) plot_px(x, y + i, on);
	endfunction

	// Applies one command to the shadow store and returns {is_read, read_data}.
	function automatic logic [8:0] apply_command(draw_item_t it);
		int x, y, w, h, t, s;
		logic [47:0] bits;
		bit b;
		x = it.pos_x; y = it.pos_y; w = it.width_px;
		h = it.height_px; t = it.outline_px;
		case (it.raw_cmd)
			CMD_PIXEL: plot_px(x, y, it.ink);
			CMD_HLINE: plot_hline(x, y, w, it.ink);
			CMD_VLINE: plot_vline(x, y, h, it.ink);
			CMD_RECT: begin
				if (t > 0) begin
					// Bands may overhang the rectangle when the outline is thick.
					for (int k = 0; k < t; k++) plot_hline(x, y + k, w, it.ink);
					for (int k = 0; k < t; k++) plot_hline(x, y + h - 1 - k, w, it.ink);
					for (int k = 0; k < t; k++) plot_vline(x + k, y, h, it.ink);
					for (int k = 0; k < t; k++) plot_vline(x + w - 1 - k, y, h, it.ink);
				end else begin
					for (int k = 0; k < h; k++) plot_hline(x, y + k, w, it.ink);
				end
			end
			CMD_GLYPH: begin
				bits = {it.glyph_main, it.glyph_tail};
				s = it.large_req ? 2 : 1;
				for (int i = 0; i < 48; i++) begin
					// Opaque glyph: ink 0 draws the inverse.
					b = bits[47 - i] ~^ it.ink;
					for (int dx = 0; dx < s; dx++)
						for (int dy = 0; dy < s; dy++)
							plot_px(x + (i / 8) * s + dx, y + (i % 8) * s + dy, b);
				end
			end
			CMD_READ: return {1'b1, (it.byte_index < FB_BYTES) ? shadow_fb[it.byte_index] : 8'h00};
			default: ;
		endcase
		return 9'h000;
	endfunction

	// Random gap: mostly none or short, sometimes long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Valid stays high from one item to the next unless a gap is taken.
	task automatic send_item(draw_item_t it);
		int gap;
		gap = idle_sender ? gap_len() : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid      <= 1'b1;
		req.cmd        <= it.raw_cmd;
		req.pos_x      <= it.pos_x;
		req.pos_y      <= it.pos_y;
		req.width_px   <= it.width_px;
		req.height_px  <= it.height_px;
		req.outline_px <= it.outline_px;
		req.ink        <= it.ink;
		req.glyph_main <= it.glyph_main;
		req.glyph_tail <= it.glyph_tail;
		req.large_req  <= it.large_req;
		req.byte_index <= it.byte_index;
		do @(posedge clk); while (!req.ready);
		owed_results.push_back(apply_command(it));
	endtask

	function automatic draw_item_t blank_item(logic [2:0] c);
		draw_item_t it;
		it.raw_cmd = c; it.cmd = cmd_t'(c);
		it.pos_x = '0; it.pos_y = '0; it.width_px = '0; it.height_px = '0;
		it.outline_px = '0; it.ink = 1'b1; it.glyph_main = '0; it.glyph_tail = '0;
		it.large_req = 1'b0; it.byte_index = '0;
		return it;
	endfunction

	// Random command with small sizes most of the time to keep runtime sane.
	function automatic draw_item_t random_item();
		draw_item_t it;
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) it = blank_item(CMD_PIXEL);
		else if (r < 27) it = blank_item(CMD_HLINE);
		else if (r < 39) it = blank_item(CMD_VLINE);
		else if (r < 49) it = blank_item(CMD_RECT);
		else if (r < 61) it = blank_item(CMD_GLYPH);
		else if (r < 97) it = blank_item(CMD_READ);
		else it = blank_item($urandom_range(0, 1) ? CMD_UNUSED_A : CMD_UNUSED_B);
		it.pos_x = $urandom; it.pos_y = $urandom;
		it.ink = $urandom; it.large_req = $urandom;
		it.glyph_main = $urandom; it.glyph_tail = $urandom;
		it.byte_index = $urandom;
		if ($urandom_range(0, 19) == 0) begin
			it.width_px = $urandom; it.height_px = $urandom; it.outline_px = $urandom;
		end else begin
			it.width_px = $urandom_range(0, 12);
			it.height_px = $urandom_range(0, 12);
			it.outline_px = $urandom_range(0, 3);
		end
		// Reads mostly aim at random bytes within the store.
		if (it.raw_cmd == CMD_READ && $urandom_range(0, 9) != 0)
			it.byte_index = $urandom_range(0, FB_BYTES - 1);
		return it;
	endfunction

	task automatic read_back_all();
		draw_item_t it;
		for (int i = 0; i < 20; i++) begin
			it = blank_item(CMD_READ);
			it.byte_index = $urandom_range(0, FB_BYTES - 1);
			send_item(it);
		end
	endtask

	// Extremes of every field, every command, zero lengths, off-display clipping,
	// thick outlines, inverted and double-scale glyphs, reads at both ends of the store.
	task automatic test_directed();
		draw_item_t it;
		it = blank_item(CMD_PIXEL); it.pos_x = 7'd127; it.pos_y = 6'd63; send_item(it);
		it = blank_item(CMD_PIXEL); it.ink = 1'b0; it.pos_x = 7'd127; it.pos_y = 6'd63;
		send_item(it);
		it = blank_item(CMD_HLINE); it.pos_x = 7'd100; it.pos_y = 6'd5; it.width_px = 8'd255;
		send_item(it);
		it = blank_item(CMD_HLINE); it.pos_x = 7'd3; it.width_px = 8'd0; send_item(it);
		it = blank_item(CMD_VLINE); it.pos_x = 7'd9; it.pos_y = 6'd40; it.height_px = 7'd127;
		send_item(it);
		it = blank_item(CMD_RECT); it.pos_x = 7'd10; it.pos_y = 6'd10; it.width_px = 8'd20;
		it.height_px = 7'd12; send_item(it);
		it = blank_item(CMD_RECT); it.pos_x = 7'd40; it.pos_y = 6'd20; it.width_px = 8'd6;
		it.height_px = 7'd5; it.outline_px = 7'd9; it.ink = 1'b0; send_item(it);
		it = blank_item(CMD_RECT); it.pos_x = 7'd0; it.pos_y = 6'd0; it.width_px = 8'd128;
		it.height_px = 7'd64; it.outline_px = 7'd1; send_item(it);
		it = blank_item(CMD_RECT); it.pos_x = 7'd120; it.pos_y = 6'd60; it.width_px = 8'd20;
		it.height_px = 7'd20; it.outline_px = 7'd127; send_item(it);
		it = blank_item(CMD_GLYPH); it.pos_x = 7'd60; it.pos_y = 6'd30;
		it.glyph_main = 32'hFFFF_FFFF; it.glyph_tail = 16'hFFFF; send_item(it);
		it = blank_item(CMD_GLYPH); it.pos_x = 7'd124; it.pos_y = 6'd58; it.ink = 1'b0;
		it.large_req = 1'b1; it.glyph_main = 32'hA5C3_0F81; it.glyph_tail = 16'h7E18;
		send_item(it);
		it = blank_item(CMD_READ); it.byte_index = 10'd1023; send_item(it);
		it = blank_item(CMD_READ); it.byte_index = 10'd0; send_item(it);
		it = blank_item(CMD_READ); it.byte_index = 10'd3 * 128 + 10'd60; send_item(it);
		send_item(blank_item(CMD_UNUSED_A));
		send_item(blank_item(CMD_UNUSED_B));
		read_back_all();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) send_item(random_item());
	endtask

	// The receiver stops for a long time while commands keep coming.
	task automatic test_backpressure();
		draw_item_t it;
		fork
			begin
				hold_on <= 1'b1;
				repeat (400) @(posedge clk);
				hold_on <= 1'b0;
			end
		join_none
		for (int i = 0; i < 12; i++) begin
			it = blank_item(CMD_READ);
			it.byte_index = $urandom_range(0, FB_BYTES - 1);
			send_item(it);
		end
	endtask

	// Result checker; the receiver's ready is driven here too.
	always @(posedge clk or negedge arst_n) begin
		logic [8:0] want;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (owed_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Unexpected result item: is_read=%0b read_data=%02h",
							rsp.is_read, rsp.read_data);
				end else begin
					want = owed_results.pop_front();
					if (rsp.is_read !== want[8] || rsp.read_data !== want[7:0]) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("Result mismatch: expected is_read=%0b data=%02h, got %0b %02h",
								want[8], want[7:0], rsp.is_read, rsp.read_data);
					end
				end
			end
			if (hold_on) begin
				rsp.ready <= 1'b0;
			end else if (idle_receiver) begin
				rsp.ready <= ($urandom_range(0, 99) < 70) ||
					(rsp.ready && $urandom_range(0, 3) != 0);
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Cycle watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		req.valid = 1'b0; req.cmd = '0; req.pos_x = '0; req.pos_y = '0;
		req.width_px = '0; req.height_px = '0; req.outline_px = '0; req.ink = 1'b0;
		req.glyph_main = '0; req.glyph_tail = '0; req.large_req = 1'b0; req.byte_index = '0;
		rsp.ready = 1'b0;
		for (int i = 0; i < FB_BYTES; i++) shadow_fb[i] = 8'h00;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_backpressure();
		idle_sender = 1'b0;
		idle_receiver = 1'b0;
		test_random(300);
		idle_sender = 1'b1;
		idle_receiver = 1'b1;
		test_random(1100);
		req.valid <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatch_count == 0 && owed_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
